FILE: rtl/dcrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrg_pkg
// Shared constants, types and tables of the display color ramp generator.
// ----------------------------------------------------------------------------
package dcrg_pkg;

  localparam int INDEX_BITS = 8;
  localparam int LEVEL_BITS = 16;
  localparam int IDX_COUNT  = 2 ** INDEX_BITS;
  localparam int IDX_MAX    = IDX_COUNT - 1;
  localparam int LEVEL_MAX  = 2 ** LEVEL_BITS - 1;

  localparam int ONE_Q15  = 32768;
  localparam int HALF_Q15 = 16384;
  localparam int LUMA_R   = 9798;
  localparam int LUMA_G   = 19235;
  localparam int LUMA_B   = 3735;

  // log2 squarings, exp2 bits, square root digits
  localparam int LOG_STEPS    = 16;
  localparam int EXP_BITS     = 16;
  localparam int SQ_STEPS     = 31;
  localparam int SQ_PER_STAGE = 4;
  localparam int SQ_STAGES    = (SQ_STEPS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
  localparam int EXP_STAGES   = EXP_BITS * SQ_STAGES;

  localparam int FRONT_STAGES = 3;
  localparam int MID_STAGES   = 2;
  localparam int BACK_STAGES  = 5;
  localparam int LOG_BASE     = FRONT_STAGES;
  localparam int MID_BASE     = LOG_BASE + LOG_STEPS;
  localparam int EXP_BASE     = MID_BASE + MID_STAGES;
  localparam int BACK_BASE    = EXP_BASE + EXP_STAGES;
  localparam int PIPE_DEPTH   = BACK_BASE + BACK_STAGES;

  localparam logic [30:0] ROOT_ONE = 31'h4000_0000;

  localparam int APB_ADDR_BITS = 5;
  localparam int REG_SEL_BITS  = 3;

  localparam logic [REG_SEL_BITS-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [REG_SEL_BITS-1:0] REG_CONTRAST   = 3'd1;
  localparam logic [REG_SEL_BITS-1:0] REG_INV_GAMMA  = 3'd2;
  localparam logic [REG_SEL_BITS-1:0] REG_RED_GAIN   = 3'd3;
  localparam logic [REG_SEL_BITS-1:0] REG_GREEN_GAIN = 3'd4;
  localparam logic [REG_SEL_BITS-1:0] REG_BLUE_GAIN  = 3'd5;
  localparam logic [REG_SEL_BITS-1:0] REG_SATURATION = 3'd6;

  typedef logic [15:0] q15_t;
  typedef q15_t idx_tab_t [IDX_COUNT];

  // index to Q1.15 intensity, rounded
  function automatic idx_tab_t build_idx_tab();
    idx_tab_t tab;
    for (int i = 0; i < IDX_COUNT; i++) begin
      tab[i] = 16'((i * ONE_Q15 + IDX_MAX / 2) / IDX_MAX);
    end
    return tab;
  endfunction

  localparam idx_tab_t IDX_TAB = build_idx_tab();

endpackage

FILE: rtl/dcrg_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrg_log
// Fractional log2 by repeated squaring, one squaring per pipeline stage.
// ----------------------------------------------------------------------------
module dcrg_log (
  input  logic                          clk_i,
  input  logic [dcrg_pkg::LOG_STEPS-1:0] en_i,
  input  logic [15:0]                   z_i,
  input  logic [3:0]                    lz_i,
  input  logic                          zero_i,
  output logic [15:0]                   frac_o,
  output logic [3:0]                    lz_o,
  output logic                          zero_o
);
  import dcrg_pkg::*;

  logic [15:0] z_q    [LOG_STEPS];
  logic [15:0] frac_q [LOG_STEPS];
  logic [3:0]  lz_q   [LOG_STEPS];
  logic        zero_q [LOG_STEPS];

  for (genvar gi = 0; gi < LOG_STEPS; gi++) begin : g_sq
    logic [15:0] z_in, frac_in, z_d, frac_d;
    logic [3:0]  lz_in;
    logic        zero_in;
    logic [31:0] sq;

    if (gi == 0) begin : g_head
      assign z_in    = z_i;
      assign frac_in = '0;
      assign lz_in   = lz_i;
      assign zero_in = zero_i;
    end else begin : g_body
      assign z_in    = z_q[gi-1];
      assign frac_in = frac_q[gi-1];
      assign lz_in   = lz_q[gi-1];
      assign zero_in = zero_q[gi-1];
    end

    assign sq = z_in * z_in;

    always_comb begin
      if (sq[31]) begin
        z_d    = sq[31:16];
        frac_d = {frac_in[14:0], 1'b1};
      end else begin
        z_d    = sq[30:15];
        frac_d = {frac_in[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[gi]) begin
        z_q[gi]    <= z_d;
        frac_q[gi] <= frac_d;
        lz_q[gi]   <= lz_in;
        zero_q[gi] <= zero_in;
      end
    end
  end

  assign frac_o = frac_q[LOG_STEPS-1];
  assign lz_o   = lz_q[LOG_STEPS-1];
  assign zero_o = zero_q[LOG_STEPS-1];

endmodule

FILE: rtl/dcrg_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrg_exp
// Fractional exp2 as a chain of square roots, one per exponent bit, each
// root taken digit by digit over several pipeline stages.
// ----------------------------------------------------------------------------
module dcrg_exp (
  input  logic                            clk_i,
  input  logic [dcrg_pkg::EXP_STAGES-1:0] en_i,
  input  logic [15:0]                     f_i,
  input  logic [4:0]                      sh_i,
  input  logic                            yz_i,
  output logic [30:0]                     root_o,
  output logic [4:0]                      sh_o,
  output logic                            yz_o
);
  import dcrg_pkg::*;

  logic [33:0] rem_q  [EXP_STAGES];
  logic [30:0] root_q [EXP_STAGES];
  logic [31:0] src_q  [EXP_STAGES];
  logic [15:0] f_q    [EXP_STAGES];
  logic [4:0]  sh_q   [EXP_STAGES];
  logic        yz_q   [EXP_STAGES];

  for (genvar gi = 0; gi < EXP_STAGES; gi++) begin : g_stage
    localparam int K = gi / SQ_STAGES;
    localparam int S = gi % SQ_STAGES;

    logic [33:0] rem_in, rem_d;
    logic [30:0] root_in, root_d;
    logic [31:0] src_in, src_d;
    logic [15:0] f_in;
    logic [4:0]  sh_in;
    logic        yz_in;

    if (gi == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = ROOT_ONE;
      assign src_in  = '0;
      assign f_in    = f_i;
      assign sh_in   = sh_i;
      assign yz_in   = yz_i;
    end else begin : g_body
      assign rem_in  = rem_q[gi-1];
      assign root_in = root_q[gi-1];
      assign src_in  = src_q[gi-1];
      assign f_in    = f_q[gi-1];
      assign sh_in   = sh_q[gi-1];
      assign yz_in   = yz_q[gi-1];
    end

    always_comb begin
      logic [33:0] rem;
      logic [33:0] trial;
      logic [30:0] root;
      logic [31:0] src;
      if (S == 0) begin
        // new root: operand is previous result, doubled when this bit is set
        src  = f_in[K] ? {root_in, 1'b0} : {1'b0, root_in};
        rem  = '0;
        root = '0;
      end else begin
        src  = src_in;
        rem  = rem_in;
        root = root_in;
      end
      for (int t = 0; t < SQ_PER_STAGE; t++) begin
        if (S * SQ_PER_STAGE + t < SQ_STEPS) begin
          rem   = {rem[31:0], src[31:30]};
          src   = {src[29:0], 2'b00};
          trial = {1'b0, root, 2'b01};
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[29:0], 1'b1};
          end else begin
            root = {root[29:0], 1'b0};
          end
        end
      end
      rem_d  = rem;
      root_d = root;
      src_d  = src;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[gi]) begin
        rem_q[gi]  <= rem_d;
        root_q[gi] <= root_d;
        src_q[gi]  <= src_d;
        f_q[gi]    <= f_in;
        sh_q[gi]   <= sh_in;
        yz_q[gi]   <= yz_in;
      end
    end
  end

  assign root_o = root_q[EXP_STAGES-1];
  assign sh_o   = sh_q[EXP_STAGES-1];
  assign yz_o   = yz_q[EXP_STAGES-1];

endmodule

FILE: rtl/display_color_ramp_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_color_ramp_generator
// Gamma, brightness, contrast, channel gain and saturation ramp generator.
// ----------------------------------------------------------------------------
// Input words carry an intensity index; each yields one output word with a
// red, green and blue level. Both channels use valid/ready.
// Throughput is one word per cycle unless the receiver stalls. The pipe has
// 3 front stages, 16 log2 squaring stages, 2 exponent stages, 128 exp2
// square root stages (16 roots of 31 digits, up to 4 digits per stage) and
// 5 gain, luma and saturation stages.
// Every stage holds its word when the next stage is full and stalled, so a
// stalled receiver fills bubbles first and then backpressures in_ready_o;
// no word is lost or repeated.
// Settings must be written over the APB port only while the pipe is empty;
// the block does not enforce it. Registers sit at byte address 4*i and read
// back their value. pready is always high. Reset empties the pipe and loads
// the neutral settings: no offset, unit contrast, gamma, gains and saturation.
// ----------------------------------------------------------------------------
module display_color_ramp_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dcrg_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dcrg_pkg::INDEX_BITS-1:0]     intensity_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dcrg_pkg::LEVEL_BITS-1:0]     red_level_o,
  output logic [dcrg_pkg::LEVEL_BITS-1:0]     green_level_o,
  output logic [dcrg_pkg::LEVEL_BITS-1:0]     blue_level_o
);
  import dcrg_pkg::*;

  // configuration
  logic [15:0] bright_q, contrast_q, gamma_q, rgain_q, ggain_q, bgain_q, sat_q;
  logic [REG_SEL_BITS-1:0] reg_sel;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= 16'd0;
      contrast_q <= 16'd16384;
      gamma_q    <= 16'd16384;
      rgain_q    <= 16'd8192;
      ggain_q    <= 16'd8192;
      bgain_q    <= 16'd8192;
      sat_q      <= 16'd8192;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BRIGHTNESS: bright_q   <= pwdata[15:0];
        REG_CONTRAST:   contrast_q <= pwdata[15:0];
        REG_INV_GAMMA:  gamma_q    <= pwdata[15:0];
        REG_RED_GAIN:   rgain_q    <= pwdata[15:0];
        REG_GREEN_GAIN: ggain_q    <= pwdata[15:0];
        REG_BLUE_GAIN:  bgain_q    <= pwdata[15:0];
        REG_SATURATION: sat_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BRIGHTNESS: prdata = {16'd0, bright_q};
      REG_CONTRAST:   prdata = {16'd0, contrast_q};
      REG_INV_GAMMA:  prdata = {16'd0, gamma_q};
      REG_RED_GAIN:   prdata = {16'd0, rgain_q};
      REG_GREEN_GAIN: prdata = {16'd0, ggain_q};
      REG_BLUE_GAIN:  prdata = {16'd0, bgain_q};
      REG_SATURATION: prdata = {16'd0, sat_q};
      default:        prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when it is empty or its successor loads
  logic [PIPE_DEPTH:0]   en;
  logic [PIPE_DEPTH-1:0] v_q, v_d, v_in;

  assign en[PIPE_DEPTH] = out_ready_i;
  for (genvar gi = 0; gi < PIPE_DEPTH; gi++) begin : g_en
    assign en[gi] = !v_q[gi] || en[gi+1];
  end

  assign v_in = {v_q[PIPE_DEPTH-2:0], in_valid_i};
  assign v_d  = (en[PIPE_DEPTH-1:0] & v_in) | (~en[PIPE_DEPTH-1:0] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[PIPE_DEPTH-1];

  // stage 0: intensity and brightness
  logic [15:0] x1_q, x1_d;
  always_comb begin
    logic signed [17:0] sum;
    sum = $signed({2'b00, IDX_TAB[intensity_index_i]})
        + $signed({{2{bright_q[15]}}, bright_q});
    if (sum < 0) begin
      x1_d = '0;
    end else if (sum > 18'sd32768) begin
      x1_d = 16'(ONE_Q15);
    end else begin
      x1_d = sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) x1_q <= x1_d;
  end

  // stage 1: contrast product
  logic signed [33:0] cp_q;
  logic signed [16:0] cdiff;
  assign cdiff = $signed({1'b0, x1_q}) - 17'sd16384;

  always_ff @(posedge clk_i) begin
    if (en[1]) cp_q <= cdiff * $signed({1'b0, contrast_q});
  end

  // stage 2: contrast clamp and normalize
  logic [15:0] zn_q, zn_d;
  logic [3:0]  lzn_q, lzn_d;
  logic        zz_q, zz_d;

  always_comb begin
    logic signed [33:0] shv;
    logic signed [19:0] t;
    logic [15:0] xc;
    logic [3:0]  p;
    shv = cp_q >>> 14;
    t   = shv[19:0] + 20'sd16384;
    if (t < 0) begin
      xc = '0;
    end else if (t > 20'sd32768) begin
      xc = 16'(ONE_Q15);
    end else begin
      xc = t[15:0];
    end
    p = '0;
    for (int b = 0; b < 16; b++) begin
      if (xc[b]) p = 4'(b);
    end
    lzn_d = 4'd15 - p;
    zn_d  = xc << lzn_d;
    zz_d  = (xc == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      zn_q  <= zn_d;
      lzn_q <= lzn_d;
      zz_q  <= zz_d;
    end
  end

  // log2
  logic [15:0] frac;
  logic [3:0]  lz;
  logic        lzero;

  dcrg_log u_log (
    .clk_i  (clk_i),
    .en_i   (en[LOG_BASE +: LOG_STEPS]),
    .z_i    (zn_q),
    .lz_i   (lzn_q),
    .zero_i (zz_q),
    .frac_o (frac),
    .lz_o   (lz),
    .zero_o (lzero)
  );

  // exponent product
  logic signed [20:0] lg;
  logic signed [37:0] ep_q;
  logic               ez_q;
  assign lg = $signed({5'b0, frac}) - $signed({1'b0, lz, 16'b0});

  always_ff @(posedge clk_i) begin
    if (en[MID_BASE]) begin
      ep_q <= lg * $signed({1'b0, gamma_q});
      ez_q <= lzero;
    end
  end

  // split exponent into integer and fraction
  logic [15:0] f_q;
  logic [4:0]  sh_q;
  logic        yz_q;
  logic [15:0] f_q_d;
  logic [4:0]  sh_q_d;
  logic        yz_q_d;

  always_comb begin
    logic signed [7:0] n;
    logic signed [7:0] sh8;
    n   = ep_q[37:30];
    sh8 = 8'sd15 - n;
    f_q_d   = ep_q[29:14];
    sh_q_d  = sh8[4:0];
    yz_q_d  = ez_q || (n <= -8'sd16);
  end

  always_ff @(posedge clk_i) begin
    if (en[MID_BASE+1]) begin
      f_q  <= f_q_d;
      sh_q <= sh_q_d;
      yz_q <= yz_q_d;
    end
  end

  // exp2
  logic [30:0] root;
  logic [4:0]  rsh;
  logic        ryz;

  dcrg_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en[EXP_BASE +: EXP_STAGES]),
    .f_i    (f_q),
    .sh_i   (sh_q),
    .yz_i   (yz_q),
    .root_o (root),
    .sh_o   (rsh),
    .yz_o   (ryz)
  );

  // power result
  logic [15:0] y_q;
  logic [30:0] rshift;
  assign rshift = root >> rsh;

  always_ff @(posedge clk_i) begin
    if (en[BACK_BASE]) y_q <= ryz ? 16'd0 : rshift[15:0];
  end

  // channel gains
  logic [15:0] cr_q, cg_q, cb_q, cr_d, cg_d, cb_d;
  logic [31:0] mr, mg, mb;
  assign mr = y_q * rgain_q;
  assign mg = y_q * ggain_q;
  assign mb = y_q * bgain_q;
  assign cr_d = (mr[31:13] > 19'd32768) ? 16'(ONE_Q15) : mr[28:13];
  assign cg_d = (mg[31:13] > 19'd32768) ? 16'(ONE_Q15) : mg[28:13];
  assign cb_d = (mb[31:13] > 19'd32768) ? 16'(ONE_Q15) : mb[28:13];

  always_ff @(posedge clk_i) begin
    if (en[BACK_BASE+1]) begin
      cr_q <= cr_d;
      cg_q <= cg_d;
      cb_q <= cb_d;
    end
  end

  // BT.601 gray
  logic [15:0] gray_q, r2_q, g2_q, b2_q;
  logic [31:0] luma;
  assign luma = 32'(LUMA_R) * 32'(cr_q) + 32'(LUMA_G) * 32'(cg_q)
              + 32'(LUMA_B) * 32'(cb_q) + 32'(HALF_Q15);

  always_ff @(posedge clk_i) begin
    if (en[BACK_BASE+2]) begin
      gray_q <= luma[30:15];
      r2_q   <= cr_q;
      g2_q   <= cg_q;
      b2_q   <= cb_q;
    end
  end

  // saturation products
  logic signed [33:0] pr_q, pg_q, pb_q;
  logic [15:0]        gray2_q;
  logic signed [16:0] dr, dg, db;
  assign dr = $signed({1'b0, r2_q}) - $signed({1'b0, gray_q});
  assign dg = $signed({1'b0, g2_q}) - $signed({1'b0, gray_q});
  assign db = $signed({1'b0, b2_q}) - $signed({1'b0, gray_q});

  always_ff @(posedge clk_i) begin
    if (en[BACK_BASE+3]) begin
      pr_q    <= $signed({1'b0, sat_q}) * dr;
      pg_q    <= $signed({1'b0, sat_q}) * dg;
      pb_q    <= $signed({1'b0, sat_q}) * db;
      gray2_q <= gray_q;
    end
  end

  // clamp and scale to level
  function automatic logic [LEVEL_BITS-1:0] to_level(logic signed [33:0] pv,
                                                      logic [15:0] gv);
    logic signed [33:0] sv;
    logic signed [20:0] t;
    logic [15:0] v;
    logic [31:0] m;
    sv = pv >>> 13;
    t  = sv[20:0] + $signed({5'b0, gv});
    if (t < 0) begin
      v = '0;
    end else if (t > 21'sd32768) begin
      v = 16'(ONE_Q15);
    end else begin
      v = t[15:0];
    end
    m = 32'(v) * 32'(LEVEL_MAX);
    return m[15 +: LEVEL_BITS];
  endfunction

  logic [LEVEL_BITS-1:0] lr_q, lg_q, lb_q;

  always_ff @(posedge clk_i) begin
    if (en[BACK_BASE+4]) begin
      lr_q <= to_level(pr_q, gray2_q);
      lg_q <= to_level(pg_q, gray2_q);
      lb_q <= to_level(pb_q, gray2_q);
    end
  end

  assign red_level_o   = lr_q;
  assign green_level_o = lg_q;
  assign blue_level_o  = lb_q;

  // checks
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  a_empty_tail_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipe tail empty but input stalled");

  a_sink_ready_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("sink ready but input stalled");

  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(v_q) == $past($countones(v_q)) + $past(32'(in_acc))
                                - $past(32'(out_acc)))
    else $error("word lost or duplicated in pipe");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[BACK_BASE-1] |-> root[30])
    else $error("exp2 root below one");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[BACK_BASE] |-> y_q <= 16'(ONE_Q15))
    else $error("power result above one");

endmodule

FILE: sim/dcrg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrg_checker
// Watches the ramp generator's ports, computes the expected red, green and
// blue levels for every accepted index and compares the output words in order.
// ----------------------------------------------------------------------------
module dcrg_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dcrg_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic [dcrg_pkg::INDEX_BITS-1:0]   intensity_index_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [dcrg_pkg::LEVEL_BITS-1:0]   red_level_o,
  input  logic [dcrg_pkg::LEVEL_BITS-1:0]   green_level_o,
  input  logic [dcrg_pkg::LEVEL_BITS-1:0]   blue_level_o,
  output int                                fail_count_o,
  output int                                pending_o
);
  import dcrg_pkg::*;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } levels_t;

  levels_t levels_q[$];

  longint offset_s;
  longint contrast_s, inv_gamma_s, red_gain_s, green_gain_s, blue_gain_s, sat_s;

  function automatic longint fdiv(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + ((longint'(1) << s) - 1)) >>> s);
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q15) return ONE_Q15;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint gamma_pow(longint x, longint g);
    int p;
    longint unsigned z, r;
    longint frac, lg, e, n, f, shamt;
    p = 15;
    frac = 0;
    r = 64'd1 << 30;
    if (x <= 0) return 0;
    while (p > 0 && ((x >> p) & 1) == 0) p--;
    z = longint'(x) << (15 - p);
    for (int k = 0; k < 16; k++) begin
      z = (z * z) >> 15;
      frac = frac << 1;
      if (z >= 65536) begin
        z >>= 1;
        frac |= 1;
      end
    end
    lg = frac - longint'(15 - p) * 65536;
    e = fdiv(lg * g, 14);
    n = fdiv(e, 16);
    f = e - n * 65536;
    for (int k = 0; k < 16; k++) begin
      if ((f >> k) & 1) r <<= 1;
      r = int_sqrt(r << 30);
    end
    shamt = 15 - n;
    if (shamt >= 63) return 0;
    return longint'(r >> shamt);
  endfunction

  function automatic longint chan_gain(longint y, longint gain);
    longint v;
    v = (y * gain) >>> 13;
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [15:0] to_level(longint v);
    return 16'((v * LEVEL_MAX) >>> 15);
  endfunction

  function automatic levels_t ramp_levels(logic [INDEX_BITS-1:0] idx);
    longint x, y, r, g, b, gray;
    levels_t lv;
    x = (longint'(idx) * ONE_Q15 + IDX_MAX / 2) / IDX_MAX;
    x = unit_clamp(x + offset_s);
    x = unit_clamp(HALF_Q15 + fdiv((x - HALF_Q15) * contrast_s, 14));
    y = gamma_pow(x, inv_gamma_s);
    r = chan_gain(y, red_gain_s);
    g = chan_gain(y, green_gain_s);
    b = chan_gain(y, blue_gain_s);
    gray = (LUMA_R * r + LUMA_G * g + LUMA_B * b + HALF_Q15) >>> 15;
    r = unit_clamp(gray + fdiv(sat_s * (r - gray), 13));
    g = unit_clamp(gray + fdiv(sat_s * (g - gray), 13));
    b = unit_clamp(gray + fdiv(sat_s * (b - gray), 13));
    lv.red = to_level(r);
    lv.green = to_level(g);
    lv.blue = to_level(b);
    return lv;
  endfunction

  assign pending_o = levels_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    levels_t exp_lv;
    if (!rst_ni) begin
      offset_s = 0;
      contrast_s = 16384;
      inv_gamma_s = 16384;
      red_gain_s = 8192;
      green_gain_s = 8192;
      blue_gain_s = 8192;
      sat_s = 8192;
      levels_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_BITS-1:2])
          REG_BRIGHTNESS: offset_s = longint'($signed(pwdata[15:0]));
          REG_CONTRAST:   contrast_s = pwdata[15:0];
          REG_INV_GAMMA:  inv_gamma_s = pwdata[15:0];
          REG_RED_GAIN:   red_gain_s = pwdata[15:0];
          REG_GREEN_GAIN: green_gain_s = pwdata[15:0];
          REG_BLUE_GAIN:  blue_gain_s = pwdata[15:0];
          REG_SATURATION: sat_s = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (levels_q.size() == 0) begin
          $display("%0t: unexpected word r=%h g=%h b=%h", $time, red_level_o,
                   green_level_o, blue_level_o);
          fail_count_o++;
        end else begin
          exp_lv = levels_q.pop_front();
          if (exp_lv.red !== red_level_o) begin
            $display("%0t: red exp %h got %h", $time, exp_lv.red, red_level_o);
            fail_count_o++;
          end
          if (exp_lv.green !== green_level_o) begin
            $display("%0t: green exp %h got %h", $time, exp_lv.green, green_level_o);
            fail_count_o++;
          end
          if (exp_lv.blue !== blue_level_o) begin
            $display("%0t: blue exp %h got %h", $time, exp_lv.blue, blue_level_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_o) levels_q.push_back(ramp_levels(intensity_index_i));
    end
  end

endmodule

FILE: sim/tb_display_color_ramp_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_display_color_ramp_generator
// Drives directed and random intensity words through several register
// settings, with bursty input and a stalling receiver; the checker compares.
// ----------------------------------------------------------------------------
module tb_display_color_ramp_generator;
  import dcrg_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [INDEX_BITS-1:0] intensity_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [LEVEL_BITS-1:0] red_level_o, green_level_o, blue_level_o;
  int fail_count, pending;

  always #5 clk_i = ~clk_i;

  display_color_ramp_generator u_top (.*);

  dcrg_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic reg_write(logic [2:0] sel, logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {sel, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  int gap_left = 0, burst_left = 0;

  // returns at the accepting edge with valid still high, so a following
  // call in the same burst drives the next word back to back
  task automatic send_index(logic [INDEX_BITS-1:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    end
    while (gap_left > 0) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    in_valid_i <= 1'b1;
    intensity_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
  endtask

  task automatic rand_config();
    logic [15:0] v[7];
    for (int i = 0; i < 7; i++) begin
      case ($urandom_range(0, 3))
        0: v[i] = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
        1: v[i] = 16'($urandom());
        default: v[i] = (i == 0) ? 16'($signed($urandom_range(0, 19660)) - 9830)
                                 : 16'($urandom_range(4096, 24576));
      endcase
      reg_write(3'(i), v[i]);
    end
    reg_write(3'd7, 16'($urandom()));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: defaults
    foreach (intensity_index_i[b]) send_index(8'd1 << b);
    send_index(8'd0);
    send_index(8'd255);
    send_index(8'd128);
    drain();
    // extremes, zero exponent, deep underflow
    reg_write(REG_BRIGHTNESS, 16'h8000);
    reg_write(REG_CONTRAST, 16'hffff);
    reg_write(REG_INV_GAMMA, 16'h0000);
    reg_write(REG_RED_GAIN, 16'hffff);
    reg_write(REG_GREEN_GAIN, 16'h0000);
    reg_write(REG_BLUE_GAIN, 16'h2000);
    reg_write(REG_SATURATION, 16'hffff);
    send_index(8'd255);
    send_index(8'd0);
    drain();
    reg_write(REG_BRIGHTNESS, 16'h7fff);
    reg_write(REG_INV_GAMMA, 16'hffff);
    reg_write(REG_CONTRAST, 16'h4000);
    send_index(8'd255);
    drain();
    reg_write(REG_BRIGHTNESS, 16'h0000);
    reg_write(REG_SATURATION, 16'h0000);
    send_index(8'd1);
    send_index(8'd2);
    send_index(8'd200);
    send_index(8'd0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      rand_config();
      for (int n = 0; n < 210; n++) send_index(INDEX_BITS'($urandom_range(0, 255)));
      in_valid_i <= 1'b0;
      drain();
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
